>>> sv/csl_pkg.sv
// ---------------------------------------------------------------------------
// csl_pkg: shared types and constants for the C subset lexer
// Character classes, keyword table, lexer mode codes and the command word
// passed from the front end to the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

  localparam int MAX_TOKEN = 32;
  localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
  localparam int POS_W     = $clog2(MAX_TOKEN);
  localparam int NUM_KW    = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // lexer modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_WORD = 3'd1;
  localparam logic [2:0] MODE_NUM  = 3'd2;
  localparam logic [2:0] MODE_BAD  = 3'd3;
  localparam logic [2:0] MODE_STR  = 3'd4;

  // token classes
  localparam logic [2:0] CLS_KEYWORD = 3'd0;
  localparam logic [2:0] CLS_IDENT   = 3'd1;
  localparam logic [2:0] CLS_NUMBER  = 3'd2;
  localparam logic [2:0] CLS_INVALID = 3'd3;
  localparam logic [2:0] CLS_SYMBOL  = 3'd4;
  localparam logic [2:0] CLS_STRING  = 3'd5;

  // follow-up action of a command
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_SYMBOL = 2'd2;

  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // one command: optional flush of the buffered token, then one action
  typedef struct packed {
    logic             do_flush;
    logic [2:0]       cls;
    logic [LEN_W-1:0] len;
    logic             trunc;
    logic [1:0]       act;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } cmd_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // ( ) + - * / { } ; > < =
  function automatic logic is_symbol(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h2B || c == 8'h2D ||
           c == 8'h2A || c == 8'h2F || c == 8'h7B || c == 8'h7D ||
           c == 8'h3B || c == 8'h3E || c == 8'h3C || c == 8'h3D;
  endfunction

  // int, void, printf, main
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    unique case (k)
      2'd0:    r = 3'd3;
      2'd1:    r = 3'd4;
      2'd2:    r = 3'd6;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (p)
          3'd0:    r = "i";
          3'd1:    r = "n";
          3'd2:    r = "t";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (p)
          3'd0:    r = "v";
          3'd1:    r = "o";
          3'd2:    r = "i";
          3'd3:    r = "d";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (p)
          3'd0:    r = "p";
          3'd1:    r = "r";
          3'd2:    r = "i";
          3'd3:    r = "n";
          3'd4:    r = "t";
          3'd5:    r = "f";
          default: r = 8'h00;
        endcase
      end
      default: begin
        unique case (p)
          3'd0:    r = "m";
          3'd1:    r = "a";
          3'd2:    r = "i";
          3'd3:    r = "n";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/csl_front.sv
// ---------------------------------------------------------------------------
// csl_front: character classifier and lexer mode tracking
// Tracks mode, length, keyword mask and overflow; turns each byte into at
// most one command for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csl_front
  import csl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output cmd_t            cmd,
  output logic            cmd_valid
);

  logic [2:0]       mode, mode_next;
  logic [LEN_W-1:0] len, len_next;
  logic [NUM_KW-1:0] mask, mask_next;
  logic             ovf, ovf_next;

  logic             c_letter, c_digit, c_word;
  logic             flush, start_idle, app;
  logic [LEN_W-1:0] base_len;
  logic [NUM_KW-1:0] base_mask, hits;
  logic             base_ovf;
  logic             kw_hit;

  assign c_letter = is_letter(in_byte);
  assign c_digit  = is_digit(in_byte);
  assign c_word   = c_letter || c_digit || (in_byte == CH_UNDERSCORE);

  // keyword still possible at flush time
  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (mask[k] && len == LEN_W'(kw_len(2'(k)))) kw_hit = 1'b1;
    end
  end

  always_comb begin
    flush      = 1'b0;
    start_idle = 1'b0;
    app        = 1'b0;
    mode_next  = mode;

    if (end_of_input) begin
      flush     = (mode != MODE_IDLE);
      mode_next = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_WORD: begin
          if (c_word) app = 1'b1;
          else begin
            flush      = 1'b1;
            start_idle = 1'b1;
          end
        end
        MODE_NUM: begin
          if (c_digit) app = 1'b1;
          else if (c_letter) mode_next = MODE_BAD;
          else begin
            flush      = 1'b1;
            start_idle = 1'b1;
          end
        end
        MODE_BAD: begin
          if (!(c_letter || c_digit)) begin
            flush      = 1'b1;
            start_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (in_byte == CH_QUOTE) begin
            flush     = 1'b1;
            mode_next = MODE_IDLE;
          end else app = 1'b1;
        end
        default: start_idle = 1'b1;
      endcase
    end

    if (end_of_input) begin
      // nothing more to start
    end else if (start_idle) begin
      mode_next = MODE_IDLE;
      if (c_letter || in_byte == CH_UNDERSCORE) begin
        app       = 1'b1;
        mode_next = MODE_WORD;
      end else if (c_digit) begin
        app       = 1'b1;
        mode_next = MODE_NUM;
      end else if (in_byte == CH_QUOTE) begin
        mode_next = MODE_STR;
      end
    end
  end

  // token state that the appended byte builds on
  always_comb begin
    if (flush || start_idle || end_of_input) begin
      base_len  = '0;
      base_mask = '1;
      base_ovf  = 1'b0;
    end else begin
      base_len  = len;
      base_mask = mask;
      base_ovf  = ovf;
    end
    for (int k = 0; k < NUM_KW; k++) begin
      hits[k] = (base_len < LEN_W'(kw_len(2'(k)))) &&
                (kw_char(2'(k), base_len[2:0]) == in_byte);
    end
  end

  always_comb begin
    len_next  = base_len;
    mask_next = base_mask;
    ovf_next  = base_ovf;

    cmd          = '0;
    cmd.do_flush = flush;
    cmd.data     = in_byte;
    cmd.pos      = base_len[POS_W-1:0];
    cmd.act      = ACT_NONE;
    cmd.len      = len;
    cmd.trunc    = ovf;
    unique case (mode)
      MODE_WORD: cmd.cls = (!ovf && kw_hit) ? CLS_KEYWORD : CLS_IDENT;
      MODE_NUM:  cmd.cls = CLS_NUMBER;
      MODE_BAD: begin
        cmd.cls   = CLS_INVALID;
        cmd.len   = '0;
        cmd.trunc = 1'b0;
      end
      default:   cmd.cls = CLS_STRING;
    endcase

    if (app) begin
      if (base_len < LEN_W'(MAX_TOKEN)) begin
        cmd.act   = ACT_APPEND;
        len_next  = base_len + 1'b1;
        mask_next = base_mask & hits;
      end else begin
        ovf_next  = 1'b1;
        mask_next = '0;
      end
    end else if (start_idle && !end_of_input && is_symbol(in_byte)) begin
      cmd.act = ACT_SYMBOL;
    end

    cmd_valid = accept && (flush || cmd.act != ACT_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      len  <= '0;
      mask <= '1;
      ovf  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
      mask <= mask_next;
      ovf  <= ovf_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/csl_cmd_fifo.sv
// ---------------------------------------------------------------------------
// csl_cmd_fifo: command queue between front and back end
// Small register FIFO; the head is visible while not empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csl_cmd_fifo
  import csl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid,
  output logic      full
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> sv/csl_back.sv
// ---------------------------------------------------------------------------
// csl_back: command executor and result output stage
// Owns the token buffer, writes appended bytes and drains flushed tokens
// one result per cycle into the output register while it is free or being read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csl_back
  import csl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_class,
  output logic [7:0]      out_byte,
  output logic            out_has,
  output logic            out_last,
  output logic            out_trunc
);

  logic [7:0]       store [MAX_TOKEN];
  logic [POS_W-1:0] idx, idx_next;
  logic             in_act, in_act_next;

  logic             load_ok, load, flushing, empty_tok, last_item, wr_en;
  logic [2:0]       n_class;
  logic [7:0]       n_byte;
  logic             n_has, n_last, n_trunc;

  assign load_ok   = !out_valid || out_ready;
  assign flushing  = head_valid && head.do_flush && !in_act;
  assign empty_tok = (head.len == '0);
  assign last_item = empty_tok || ((LEN_W'(idx) + 1'b1) == head.len);

  always_comb begin
    load        = 1'b0;
    pop         = 1'b0;
    wr_en       = 1'b0;
    idx_next    = idx;
    in_act_next = in_act;
    n_class     = head.cls;
    n_byte      = empty_tok ? 8'h00 : store[idx];
    n_has       = !empty_tok;
    n_last      = last_item;
    n_trunc     = head.trunc;

    if (flushing) begin
      if (load_ok) begin
        load = 1'b1;
        if (last_item) begin
          idx_next = '0;
          // an append can share the cycle of the last read
          if (head.act == ACT_SYMBOL) in_act_next = 1'b1;
          else begin
            pop   = 1'b1;
            wr_en = (head.act == ACT_APPEND);
          end
        end else idx_next = idx + 1'b1;
      end
    end else if (head_valid) begin
      n_class = CLS_SYMBOL;
      n_byte  = head.data;
      n_has   = 1'b1;
      n_last  = 1'b1;
      n_trunc = 1'b0;
      unique case (head.act)
        ACT_APPEND: begin
          wr_en       = 1'b1;
          pop         = 1'b1;
          in_act_next = 1'b0;
        end
        ACT_SYMBOL: begin
          if (load_ok) begin
            load        = 1'b1;
            pop         = 1'b1;
            in_act_next = 1'b0;
          end
        end
        default: begin
          pop         = 1'b1;
          in_act_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[head.pos] <= head.data;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_class <= n_class;
      out_byte  <= n_byte;
      out_has   <= n_has;
      out_last  <= n_last;
      out_trunc <= n_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      in_act    <= 1'b0;
    end else begin
      idx    <= idx_next;
      in_act <= in_act_next;
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/c_subset_lexer.sv
// ---------------------------------------------------------------------------
// c_subset_lexer: byte-stream tokenizer for a small C subset
// Classifies source bytes into keyword, identifier, number, invalid, symbol
// and string tokens and streams each token out as a run of bytes.
// ---------------------------------------------------------------------------
// The block takes one source byte per transaction on the s_ side (s_tlast
// marks end of input: the pending token is flushed, an open string is
// closed) and returns each finished token on the m_ side as a run of
// transactions, one byte each, with m_tlast on the final byte. A byte is
// taken every cycle as long as the 4-entry command queue between the front
// end and the back end has room. The back end drains a token one item per
// cycle through the output register while the receiver is ready; a symbol
// that directly follows a flushed token comes out as its own item after
// the token, and an invalid token or empty string is a single item
// without a byte. Tokens longer than 32 bytes are cut at 32 and carry the
// truncated flag on every item. Whitespace and unknown characters produce
// nothing; the byte that ends an identifier, number or invalid token starts
// the next token. No clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer
  import csl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // input bytes
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // end_of_input
  // token items
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] token_byte
  output logic [4:0]      m_tuser,   // [2:0] token_class, [3] has_byte, [4] truncated
  output logic            m_tlast    // last byte of a token
);

  cmd_t       cmd, head;
  logic       cmd_valid, head_valid, pop, full, accept;
  logic [2:0] out_class;
  logic       out_has, out_trunc;

  // front end may take a byte whenever a command slot is free
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  csl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (s_tdata),
    .end_of_input (s_tlast),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid)
  );

  csl_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_data  (cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  csl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_class  (out_class),
    .out_byte   (m_tdata),
    .out_has    (out_has),
    .out_last   (m_tlast),
    .out_trunc  (out_trunc)
  );

  assign m_tuser = {out_trunc, out_has, out_class};

endmodule

`default_nettype wire

>>> sim/lexer_token_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lexer_token_checker: scoreboard for the C subset lexer streams
// Follows the tokenizer state on every accepted source byte, queues the token
// items that byte releases and checks them in order against the output side.
// ---------------------------------------------------------------------------
module lexer_token_checker
  import csl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic [4:0] m_tuser,
  input  logic       m_tlast,
  output int         mismatches,
  output int         items_due,
  output int         bytes_in,
  output int         items_out,
  output int         tokens_out,
  output int         cut_tokens
);

  // field order matches {class, byte, has_byte, last, truncated}
  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] ch;
    logic       has;
    logic       fin;
    logic       trunc;
  } tok_item_t;

  string kw_word [4] = '{"int", "void", "printf", "main"};
  string sym_set = "(){}+-*/;<>=";

  logic [2:0] mode = MODE_IDLE;
  logic [7:0] tok_text [MAX_TOKEN];
  int         tok_len = 0;
  logic [3:0] kw_live = 4'hF;
  logic       tok_over = 1'b0;
  tok_item_t  token_items_due [$];

  int errors = 0;
  int n_bytes = 0;
  int n_items = 0;
  int n_tokens = 0;
  int n_cut = 0;

  function automatic logic alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic sym(logic [7:0] c);
    for (int i = 0; i < sym_set.len(); i++)
      if (sym_set[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_token();
    tok_len  = 0;
    kw_live  = 4'hF;
    tok_over = 1'b0;
  endfunction

  // keeps the keyword prefix mask current; bytes past the buffer are dropped
  function automatic void take_char(logic [7:0] c);
    for (int k = 0; k < 4; k++)
      if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c) kw_live[k] = 1'b0;
    if (tok_len < MAX_TOKEN) begin
      tok_text[tok_len] = c;
      tok_len++;
    end else begin
      tok_over = 1'b1;
      kw_live  = 4'h0;
    end
  endfunction

  function automatic void queue_item(logic [2:0] cls, logic [7:0] ch, logic has,
                                     logic fin, logic trunc);
    tok_item_t it;
    it.cls   = cls;
    it.ch    = ch;
    it.has   = has;
    it.fin   = fin;
    it.trunc = trunc;
    token_items_due.push_back(it);
  endfunction

  function automatic void release_token(logic [2:0] cls);
    if (tok_len == 0) begin
      queue_item(cls, 8'h00, 1'b0, 1'b1, tok_over);
    end else begin
      for (int i = 0; i < tok_len; i++)
        queue_item(cls, tok_text[i], 1'b1, i == tok_len - 1, tok_over);
    end
  endfunction

  function automatic logic [2:0] word_cls();
    if (tok_over) return CLS_IDENT;
    for (int k = 0; k < 4; k++)
      if (kw_live[k] && kw_word[k].len() == tok_len) return CLS_KEYWORD;
    return CLS_IDENT;
  endfunction

  function automatic void close_token();
    case (mode)
      MODE_WORD: release_token(word_cls());
      MODE_NUM:  release_token(CLS_NUMBER);
      MODE_BAD:  queue_item(CLS_INVALID, 8'h00, 1'b0, 1'b1, 1'b0);
      MODE_STR:  release_token(CLS_STRING);
      default: ;
    endcase
    mode = MODE_IDLE;
    clear_token();
  endfunction

  function automatic void open_token(logic [7:0] c);
    mode = MODE_IDLE;
    clear_token();
    if (alpha(c) || c == CH_UNDERSCORE) begin
      take_char(c);
      mode = MODE_WORD;
    end else if (digit(c)) begin
      take_char(c);
      mode = MODE_NUM;
    end else if (sym(c)) begin
      queue_item(CLS_SYMBOL, c, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_QUOTE) begin
      mode = MODE_STR;
    end
  endfunction

  // one source byte; a byte that ends a word, number or invalid token
  // falls through to start the next one
  function automatic void lex_byte(logic [7:0] c, logic eoi);
    if (eoi) begin
      close_token();
      return;
    end
    case (mode)
      MODE_WORD: begin
        if (alpha(c) || digit(c) || c == CH_UNDERSCORE) begin
          take_char(c);
          return;
        end
      end
      MODE_NUM: begin
        if (digit(c)) begin
          take_char(c);
          return;
        end
        if (alpha(c)) begin
          mode = MODE_BAD;
          return;
        end
      end
      MODE_BAD: begin
        if (alpha(c) || digit(c)) return;
      end
      MODE_STR: begin
        if (c == CH_QUOTE) close_token();
        else take_char(c);
        return;
      end
      default: begin
        open_token(c);
        return;
      end
    endcase
    close_token();
    open_token(c);
  endfunction

  always @(posedge clk) begin : monitor
    tok_item_t got;
    tok_item_t want;
    if (rst) begin
      mode = MODE_IDLE;
      clear_token();
      token_items_due.delete();
    end else begin
      // an output item can never stem from a byte taken at the same edge
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata, s_tlast);
        n_bytes++;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser[2:0], m_tdata, m_tuser[3], m_tlast, m_tuser[4]};
        n_items++;
        if (m_tlast) n_tokens++;
        if (m_tlast && m_tuser[4]) n_cut++;
        if (token_items_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t: token item with none expected: cls %0d byte %02h has %0b last %0b trunc %0b",
                     $time, got.cls, got.ch, got.has, got.fin, got.trunc);
        end else begin
          want = token_items_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%t: token item mismatch: expected cls %0d byte %02h has %0b last %0b",
                        " trunc %0b, got cls %0d byte %02h has %0b last %0b trunc %0b"},
                       $time, want.cls, want.ch, want.has, want.fin, want.trunc,
                       got.cls, got.ch, got.has, got.fin, got.trunc);
          end
        end
      end
    end
    mismatches <= errors;
    items_due  <= token_items_due.size();
    bytes_in   <= n_bytes;
    items_out  <= n_items;
    tokens_out <= n_tokens;
    cut_tokens <= n_cut;
  end

endmodule

>>> sim/c_subset_lexer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c_subset_lexer_tb: stream testbench for the C subset lexer
// Feeds a short hand-picked source text, then random token sequences with
// noise, under three idle mixes, one long output stall and drain pauses; a
// separate checker predicts and compares every token transaction.
// ---------------------------------------------------------------------------
module c_subset_lexer_tb;
  import csl_pkg::*;

  localparam int HOLD_CYCLES = 150;   // long output stall
  localparam int QUIET_LIMIT = 2000;  // cycles without any transaction

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [4:0] m_tuser;
  logic       m_tlast;

  int mismatches, items_due, bytes_in, items_out, tokens_out, cut_tokens;

  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  logic stall_req = 1'b0;
  logic stall_seen = 1'b0;
  int   hold_left = 0;

  // source queue entries: {end_of_input, byte}
  logic [8:0] src_q [$];
  string kw_list [4] = '{"int", "void", "printf", "main"};
  string sym_list = "(){}+-*/;<>=";

  c_subset_lexer dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  lexer_token_checker chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .mismatches, .items_due, .bytes_in, .items_out, .tokens_out, .cut_tokens
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random idling, or a counted hold-off when stall_req toggles
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic void put_byte(logic [7:0] b);
    src_q.push_back({1'b0, b});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_eoi();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));  // byte is ignored with end of input
    src_q.push_back({1'b1, junk});
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_digit();
    logic [7:0] base;
    base = "0";
    return base + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return pick_letter();
    if (r < 62) return pick_digit();
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] pick_string_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic void put_sep();
    int n;
    if ($urandom_range(0, 99) < 60) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++)
        case ($urandom_range(0, 2))
          0: put_byte(" ");
          1: put_byte(8'h09);
          default: put_byte(8'h0A);
        endcase
    end
  endfunction

  // identifier, number or string around the buffer size (31..40 bytes)
  function automatic int queue_long();
    int n, sel;
    n   = $urandom_range(31, 40);
    sel = $urandom_range(0, 2);
    if (sel == 2) put_byte(CH_QUOTE);
    for (int i = 0; i < n; i++)
      case (sel)
        0: put_byte(i == 0 ? pick_letter() : pick_word_char());
        1: put_byte(pick_digit());
        default: put_byte(pick_string_char());
      endcase
    if (sel == 2) put_byte(CH_QUOTE);
    return n;
  endfunction

  // mostly well-formed tokens with random content, some noise and cut strings
  function automatic int queue_token();
    int kind, n, cnt;
    string w;
    kind = $urandom_range(0, 99);
    cnt  = 0;
    if (kind < 15) begin
      w = kw_list[$urandom_range(0, 3)];
      put_text(w);
      cnt = w.len();
    end else if (kind < 25) begin
      // near miss: keyword prefix or keyword with a tail
      w = kw_list[$urandom_range(0, 3)];
      if ($urandom_range(0, 1)) begin
        w = w.substr(0, w.len() - 2);
        put_text(w);
        cnt = w.len();
      end else begin
        put_text(w);
        put_byte(pick_word_char());
        cnt = w.len() + 1;
      end
    end else if (kind < 45) begin
      n = $urandom_range(1, 6);
      put_byte($urandom_range(0, 3) == 0 ? CH_UNDERSCORE : pick_letter());
      for (int i = 1; i < n; i++) put_byte(pick_word_char());
      cnt = n;
    end else if (kind < 55) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) put_byte(pick_digit());
      cnt = n;
    end else if (kind < 62) begin
      // digits run into letters
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put_byte(pick_digit());
      put_byte(pick_letter());
      cnt = n + 1;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) put_byte($urandom_range(0, 1) ? pick_letter() : pick_digit());
      cnt += n;
    end else if (kind < 80) begin
      put_byte(sym_list[$urandom_range(0, 11)]);
      cnt = 1;
    end else if (kind < 90) begin
      n = $urandom_range(0, 6);
      put_byte(CH_QUOTE);
      for (int i = 0; i < n; i++) put_byte(pick_string_char());
      if ($urandom_range(0, 99) < 85) put_byte(CH_QUOTE);
      else put_eoi();
      cnt = n + 2;
    end else if (kind < 94) begin
      cnt = queue_long();
    end else if (kind < 97) begin
      put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_eoi();
      cnt = 1;
    end
    put_sep();
    return cnt;
  endfunction

  task automatic send_item(logic [7:0] b, logic eoi);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_queued();
    logic [8:0] e;
    while (src_q.size() != 0) begin
      e = src_q.pop_front();
      send_item(e[7:0], e[8]);
    end
  endtask

  // hold the source until every queued token item has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (items_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int budget, logic with_hold);
    int   done;
    logic hold_sent;
    hold_sent = 1'b0;
    done = queue_long();
    put_byte(" ");
    send_queued();
    while (done < budget) begin
      done += queue_token();
      if (with_hold && !hold_sent && done >= budget / 3) begin
        // output held off while bytes keep coming: the queue fills up
        stall_req <= ~stall_req;
        hold_sent = 1'b1;
      end
      send_queued();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 38;
    recv_gap_pct <= 58;

    // keyword, invalid ended by a symbol, number then underscore word,
    // unknown bytes, empty string, string closed by end of input,
    // end of input while idle, keyword flushed by end of input
    put_text("int 1a2;9_v");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    put_byte("x");
    put_byte(8'hFF);
    put_eoi();
    put_eoi();
    put_text("main");
    put_eoi();
    send_queued();
    wait_drained();

    run_phase(105, 1'b0);
    send_gap_pct = 58;
    recv_gap_pct <= 38;
    run_phase(105, 1'b0);
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    run_phase(105, 1'b1);

    repeat (20) @(posedge clk);
    $display("covered %0d source bytes giving %0d token items in %0d tokens, %0d cut at %0d",
             bytes_in, items_out, tokens_out, cut_tokens, MAX_TOKEN);
    $display("idle mixes 38/58, 58/38 and none, a %0d-cycle output stall, drains per phase",
             HOLD_CYCLES);
    if (mismatches == 0 && items_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
